// ===== rtl/nec_pulse_frame_transmitter_assert.svh =====
// Assertion helpers shared by the transmitter modules.
`ifndef NEC_PULSE_FRAME_TRANSMITTER_ASSERT_SVH
`define NEC_PULSE_FRAME_TRANSMITTER_ASSERT_SVH

`ifndef SYNTH
`define NPFT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NPFT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NPFT_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define NPFT_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/npft_pkg.sv =====
`timescale 1ns / 1ps

package npft_pkg;

  localparam int QDepth   = 2;
  localparam int PtrW     = 1;
  localparam int CntW     = 2;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;
  localparam int TickW    = 16;
  localparam int CodeW    = 16;
  localparam int CmdW     = 8;
  localparam int FrameW   = 32;
  localparam int BitsW    = 6;
  localparam logic [BitsW-1:0] FrameBitCount = 6'd33;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_SEND = 1'b1
  } op_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_START_MARK  = 3'd1,
    PH_START_SPACE = 3'd2,
    PH_BIT_MARK    = 3'd3,
    PH_BIT_SPACE   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    REG_CUSTOM_CODE_A     = 3'd0,
    REG_CUSTOM_CODE_B     = 3'd1,
    REG_START_MARK_TICKS  = 3'd2,
    REG_START_SPACE_TICKS = 3'd3,
    REG_BIT_MARK_TICKS    = 3'd4,
    REG_ZERO_SPACE_TICKS  = 3'd5,
    REG_ONE_SPACE_TICKS   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    op_kind_t        kind;
    logic [CmdW-1:0] command;
    logic            use_second_code;
  } op_t;

  typedef struct packed {
    logic [CodeW-1:0] custom_code_a;
    logic [CodeW-1:0] custom_code_b;
    logic [TickW-1:0] start_mark_ticks;
    logic [TickW-1:0] start_space_ticks;
    logic [TickW-1:0] bit_mark_ticks;
    logic [TickW-1:0] zero_space_ticks;
    logic [TickW-1:0] one_space_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
  } res_t;

endpackage

// ===== rtl/npft_cfg.sv =====
`timescale 1ns / 1ps

module npft_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [npft_pkg::AddrW-1:0] paddr,
  input  logic [npft_pkg::DataW-1:0] pwdata,
  output logic [npft_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output npft_pkg::cfg_t             cfg
);

  npft_pkg::cfg_t cfg_r;
  npft_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [15:0]    wdata;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wdata  = pwdata[15:0];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[4:2])
        npft_pkg::REG_CUSTOM_CODE_A:     cfg_nxt.custom_code_a     = wdata;
        npft_pkg::REG_CUSTOM_CODE_B:     cfg_nxt.custom_code_b     = wdata;
        npft_pkg::REG_START_MARK_TICKS:  cfg_nxt.start_mark_ticks  = wdata;
        npft_pkg::REG_START_SPACE_TICKS: cfg_nxt.start_space_ticks = wdata;
        npft_pkg::REG_BIT_MARK_TICKS:    cfg_nxt.bit_mark_ticks    = wdata;
        npft_pkg::REG_ZERO_SPACE_TICKS:  cfg_nxt.zero_space_ticks  = wdata;
        npft_pkg::REG_ONE_SPACE_TICKS:   cfg_nxt.one_space_ticks   = wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      npft_pkg::REG_CUSTOM_CODE_A:     prdata = {16'd0, cfg_r.custom_code_a};
      npft_pkg::REG_CUSTOM_CODE_B:     prdata = {16'd0, cfg_r.custom_code_b};
      npft_pkg::REG_START_MARK_TICKS:  prdata = {16'd0, cfg_r.start_mark_ticks};
      npft_pkg::REG_START_SPACE_TICKS: prdata = {16'd0, cfg_r.start_space_ticks};
      npft_pkg::REG_BIT_MARK_TICKS:    prdata = {16'd0, cfg_r.bit_mark_ticks};
      npft_pkg::REG_ZERO_SPACE_TICKS:  prdata = {16'd0, cfg_r.zero_space_ticks};
      npft_pkg::REG_ONE_SPACE_TICKS:   prdata = {16'd0, cfg_r.one_space_ticks};
      default:                         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.custom_code_a     <= 16'd0;
      cfg_r.custom_code_b     <= 16'd0;
      cfg_r.start_mark_ticks  <= 16'd900;
      cfg_r.start_space_ticks <= 16'd450;
      cfg_r.bit_mark_ticks    <= 16'd56;
      cfg_r.zero_space_ticks  <= 16'd56;
      cfg_r.one_space_ticks   <= 16'd169;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/npft_front.sv =====
`timescale 1ns / 1ps
`include "nec_pulse_frame_transmitter_assert.svh"

module npft_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic                      in_kind,
  input  logic [npft_pkg::CmdW-1:0] in_command,
  input  logic                      in_use_second_code,
  output logic                      op_valid,
  output npft_pkg::op_t             op,
  input  logic                      op_deq
);

  npft_pkg::op_t              q_r [npft_pkg::QDepth];
  logic [npft_pkg::PtrW-1:0]  wr_ptr_r;
  logic [npft_pkg::PtrW-1:0]  rd_ptr_r;
  logic [npft_pkg::CntW-1:0]  cnt_r;
  logic [npft_pkg::CntW-1:0]  cnt_nxt;
  logic                       enq;
  npft_pkg::op_t              op_in;

  assign full     = (cnt_r == npft_pkg::CntW'(npft_pkg::QDepth));
  assign enq      = push & ~full;
  assign op_valid = (cnt_r != '0);
  assign op       = q_r[rd_ptr_r];

  // classify the incoming item
  always_comb begin
    op_in.kind            = npft_pkg::op_kind_t'(in_kind);
    op_in.command         = in_command;
    op_in.use_second_code = in_use_second_code;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (enq && !op_deq) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!enq && op_deq) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (enq) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (op_deq) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= op_in;
    end
  end

  `NPFT_ASSERT_IMP(a_front_cnt_bound, clk, rst_n, 1'b1, cnt_r <= 2'd2)
  `NPFT_ASSERT_IMP(a_front_no_underflow, clk, rst_n, op_deq, cnt_r != 2'd0)
  `NPFT_ASSERT_NXT(a_front_enq_visible, clk, rst_n, enq, op_valid)

endmodule

// ===== rtl/npft_engine.sv =====
`timescale 1ns / 1ps
`include "nec_pulse_frame_transmitter_assert.svh"

module npft_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  npft_pkg::cfg_t cfg,
  input  logic           op_valid,
  input  npft_pkg::op_t  op,
  output logic           op_deq,
  output logic           empty,
  input  logic           pop,
  output logic           out_line_level,
  output logic           out_busy_res,
  output logic           out_accepted
);

  npft_pkg::phase_t              phase_r, phase_nxt;
  logic [npft_pkg::FrameW-1:0]   frame_r, frame_nxt;
  logic [npft_pkg::BitsW-1:0]    bits_left_r, bits_left_nxt;
  logic [npft_pkg::TickW-1:0]    ticks_r, ticks_nxt;
  logic                          cur_bit_r, cur_bit_nxt;
  logic                          load_bit;
  logic [npft_pkg::CodeW-1:0]    code;
  npft_pkg::res_t                res;

  npft_pkg::res_t                oq_r [npft_pkg::QDepth];
  logic [npft_pkg::PtrW-1:0]     owr_ptr_r;
  logic [npft_pkg::PtrW-1:0]     ord_ptr_r;
  logic [npft_pkg::CntW-1:0]     ocnt_r;
  logic [npft_pkg::CntW-1:0]     ocnt_nxt;
  logic                          fire;
  logic                          deq_out;

  assign fire    = op_valid & (ocnt_r != npft_pkg::CntW'(npft_pkg::QDepth));
  assign op_deq  = fire;
  assign empty   = (ocnt_r == '0);
  assign deq_out = pop & ~empty;
  assign code    = op.use_second_code ? cfg.custom_code_b : cfg.custom_code_a;

  assign out_line_level = oq_r[ord_ptr_r].line_level;
  assign out_busy_res   = oq_r[ord_ptr_r].busy_res;
  assign out_accepted   = oq_r[ord_ptr_r].accepted;

  always_comb begin
    phase_nxt     = phase_r;
    frame_nxt     = frame_r;
    bits_left_nxt = bits_left_r;
    ticks_nxt     = ticks_r;
    cur_bit_nxt   = cur_bit_r;
    load_bit      = 1'b0;
    res.accepted  = 1'b0;

    if (op.kind == npft_pkg::OP_SEND) begin
      // drop a send that arrives mid-frame
      if (phase_r == npft_pkg::PH_IDLE) begin
        frame_nxt     = {~op.command, op.command, code[7:0], code[15:8]};
        bits_left_nxt = npft_pkg::FrameBitCount;
        cur_bit_nxt   = 1'b0;
        phase_nxt     = npft_pkg::PH_START_MARK;
        ticks_nxt     = cfg.start_mark_ticks;
        res.accepted  = 1'b1;
      end
    end else if (phase_r != npft_pkg::PH_IDLE) begin
      if (ticks_r > 16'd1) begin
        ticks_nxt = ticks_r - 16'd1;
      end else begin
        unique case (phase_r)
          npft_pkg::PH_START_MARK: begin
            phase_nxt = npft_pkg::PH_START_SPACE;
            ticks_nxt = cfg.start_space_ticks;
          end
          npft_pkg::PH_START_SPACE: load_bit = 1'b1;
          npft_pkg::PH_BIT_MARK: begin
            phase_nxt = npft_pkg::PH_BIT_SPACE;
            ticks_nxt = cur_bit_r ? cfg.one_space_ticks : cfg.zero_space_ticks;
          end
          npft_pkg::PH_BIT_SPACE: begin
            if (bits_left_r == '0) begin
              phase_nxt   = npft_pkg::PH_IDLE;
              ticks_nxt   = '0;
              cur_bit_nxt = 1'b0;
            end else begin
              load_bit = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    if (load_bit) begin
      // the trailing bit is always a one
      if (bits_left_r > 6'd1) begin
        cur_bit_nxt = frame_r[0];
        frame_nxt   = {1'b0, frame_r[npft_pkg::FrameW-1:1]};
      end else begin
        cur_bit_nxt = 1'b1;
      end
      bits_left_nxt = bits_left_r - 6'd1;
      phase_nxt     = npft_pkg::PH_BIT_MARK;
      ticks_nxt     = cfg.bit_mark_ticks;
    end

    res.line_level = ~((phase_nxt == npft_pkg::PH_START_MARK) ||
                       (phase_nxt == npft_pkg::PH_BIT_MARK));
    res.busy_res   = (phase_nxt != npft_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= npft_pkg::PH_IDLE;
      frame_r     <= '0;
      bits_left_r <= '0;
      ticks_r     <= '0;
      cur_bit_r   <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      frame_r     <= frame_nxt;
      bits_left_r <= bits_left_nxt;
      ticks_r     <= ticks_nxt;
      cur_bit_r   <= cur_bit_nxt;
    end
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (fire && !deq_out) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (!fire && deq_out) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (fire) begin
        owr_ptr_r <= owr_ptr_r + 1'b1;
      end
      if (deq_out) begin
        ord_ptr_r <= ord_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      oq_r[owr_ptr_r] <= res;
    end
  end

  `NPFT_ASSERT_IMP(a_eng_ocnt_bound, clk, rst_n, 1'b1, ocnt_r <= 2'd2)
  `NPFT_ASSERT_IMP(a_eng_bits_bound, clk, rst_n, 1'b1, bits_left_r <= 6'd33)
  `NPFT_ASSERT_IMP(a_eng_idle_clean, clk, rst_n, phase_r == npft_pkg::PH_IDLE,
    (ticks_r == 16'd0) && (bits_left_r == 6'd0))
  `NPFT_ASSERT_IMP(a_eng_accept_busy, clk, rst_n, fire && res.accepted,
    res.busy_res && !res.line_level)

endmodule

// ===== rtl/nec_pulse_frame_transmitter.sv =====
`timescale 1ns / 1ps
// Pulse-distance infrared frame transmitter on one active-low line.
// Input channel (push/full): each item is a tick (kind 0) or a send request
// (kind 1, with command and custom code select). Result channel (empty/pop):
// exactly one result per item, in order: line level after that item, busy,
// and whether a send request started a frame. Send requests during a frame
// are dropped and report accepted = 0.
// Configuration goes over the APB-style port: seven 16-bit registers at byte
// addresses 0x00..0x18 (custom codes and mark/space lengths in ticks).
// Throughput: one item per clock cycle while the result queue is not full;
// the frame engine updates its phase and tick countdown once per item.
// An accepted item is registered in the input queue; when the result queue
// has room, the engine takes it and its result is registered in the result
// queue, from where it can be popped.
// A 2-entry queue on each side decouples the sides: when the receiver
// stalls, results collect, then the input queue fills and full rises.
// Reset: both queues empty, line idle high, timing registers at defaults.
module nec_pulse_frame_transmitter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_kind,
  input  logic [npft_pkg::CmdW-1:0]  in_command,
  input  logic                       in_use_second_code,
  output logic                       empty,
  input  logic                       pop,
  output logic                       out_line_level,
  output logic                       out_busy_res,
  output logic                       out_accepted,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [npft_pkg::AddrW-1:0] paddr,
  input  logic [npft_pkg::DataW-1:0] pwdata,
  output logic [npft_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  npft_pkg::cfg_t cfg;
  npft_pkg::op_t  op;
  logic           op_valid;
  logic           op_deq;

  npft_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  npft_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_kind            (in_kind),
    .in_command         (in_command),
    .in_use_second_code (in_use_second_code),
    .op_valid           (op_valid),
    .op                 (op),
    .op_deq             (op_deq)
  );

  npft_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .op_valid       (op_valid),
    .op             (op),
    .op_deq         (op_deq),
    .empty          (empty),
    .pop            (pop),
    .out_line_level (out_line_level),
    .out_busy_res   (out_busy_res),
    .out_accepted   (out_accepted)
  );

endmodule
